### hdl/ckas_pkg.sv
// Shared types, menu codes and the field adjust function for the clock key
// setting and alarm core. No dependencies; used by ckas_step and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ckas_pkg;

	// Stream widths: fields packed from bit 0 up, padded to whole bytes.
	localparam int unsigned IN_TDATA_W  = 40;
	localparam int unsigned OUT_TDATA_W = 56;

	// Menu codes
	localparam logic [3:0] MENU_RUN        = 4'd0;
	localparam logic [3:0] MENU_HOUR       = 4'd1;
	localparam logic [3:0] MENU_MINUTE     = 4'd2;
	localparam logic [3:0] MENU_HOUR_WRAP  = 4'd3;
	localparam logic [3:0] MENU_DATE       = 4'd4;
	localparam logic [3:0] MENU_DAY        = 4'd5;
	localparam logic [3:0] MENU_MONTH      = 4'd6;
	localparam logic [3:0] MENU_YEAR       = 4'd7;
	localparam logic [3:0] MENU_DATE_WRAP  = 4'd8;
	localparam logic [3:0] MENU_ALARM      = 4'd9;
	localparam logic [3:0] MENU_ALARM_ON   = 4'd10;
	localparam logic [3:0] MENU_ALARM_HOUR = 4'd11;
	localparam logic [3:0] MENU_ALARM_MIN  = 4'd12;
	localparam logic [3:0] MENU_ALARM_WRAP = 4'd13;

	// Field limits
	localparam logic [6:0] LIM_HOUR   = 7'd23;
	localparam logic [6:0] LIM_MINUTE = 7'd59;
	localparam logic [6:0] LIM_DAY    = 7'd31;
	localparam logic [6:0] LIM_MONTH  = 7'd12;
	localparam logic [6:0] LIM_YEAR   = 7'd99;
	localparam logic [5:0] CHIME_SECS = 6'd6;

	typedef struct packed {
		logic       mode_key;
		logic       set_key;
		logic       up_key;
		logic       down_key;
		logic [5:0] rtc_second;
		logic [5:0] rtc_minute;
		logic [4:0] rtc_hour;
		logic [4:0] rtc_day;
		logic [3:0] rtc_month;
		logic [6:0] rtc_year;
	} in_item_t;

	typedef struct packed {
		logic [3:0] menu_mode;
		logic [4:0] shown_hour;
		logic [5:0] shown_minute;
		logic [5:0] shown_second;
		logic [4:0] shown_day;
		logic [3:0] shown_month;
		logic [6:0] shown_year;
		logic [4:0] alarm_hour_out;
		logic [5:0] alarm_minute_out;
		logic       alarm_enabled;
		logic       write_back;
		logic       beep;
	} out_item_t;

	typedef struct packed {
		logic [3:0] menu;
		logic       mode_prev;
		logic       set_prev;
		logic       up_prev;
		logic       down_prev;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] year;
		logic [4:0] alarm_hour;
		logic [5:0] alarm_minute;
		logic       alarm_on;
		logic       alarm_armed;
		logic       dirty;
	} state_t;

	localparam state_t STATE_RESET = '{
		menu: MENU_RUN, mode_prev: 1'b1, set_prev: 1'b1, up_prev: 1'b1,
		down_prev: 1'b1, hour: '0, minute: '0, second: '0, day: '0, month: '0,
		year: '0, alarm_hour: '0, alarm_minute: '0, alarm_on: 1'b0,
		alarm_armed: 1'b0, dirty: 1'b0
	};

	// Up step wraps past the limit, down step wraps from zero to the limit.
	function automatic logic [6:0] adjust(input logic [6:0] v, input logic up,
			input logic dn, input logic [6:0] limit, input logic [6:0] wrap_to);
		logic [7:0] inc;
		logic [6:0] r;
		inc = {1'b0, v} + 8'd1;
		r   = v;
		if (up) begin
			r = (inc > {1'b0, limit}) ? wrap_to : inc[6:0];
		end
		if (dn) begin
			r = (r == 7'd0) ? limit : r - 7'd1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### hdl/ckas_step.sv
// Next-state and result logic for one poll request of the clock key core.
// Depends on ckas_pkg for item, result and state types and the menu codes.
`timescale 1ns / 1ps
`default_nettype none

module ckas_step (
	input  wire ckas_pkg::state_t   cur,
	input  wire ckas_pkg::in_item_t item,
	output ckas_pkg::state_t        nxt,
	output ckas_pkg::out_item_t     res
);

	logic       mode_edge;
	logic       set_edge;
	logic       up_edge;
	logic       down_edge;
	logic [3:0] menu;
	logic [3:0] menu_inc;
	logic       edit_menu;
	logic       wb;
	logic       ring;
	logic       chime;
	logic [6:0] min_plus;

	always_comb begin
		nxt       = cur;
		wb        = 1'b0;
		ring      = 1'b0;
		up_edge   = 1'b0;
		down_edge = 1'b0;
		mode_edge = cur.mode_prev & ~item.mode_key;
		set_edge  = cur.set_prev & ~item.set_key;
		nxt.mode_prev = item.mode_key;
		nxt.set_prev  = item.set_key;

		// Mode key cycles run -> date -> alarm -> run; any edit menu exits to run.
		menu = cur.menu;
		if (mode_edge) begin
			if (menu == ckas_pkg::MENU_RUN) begin
				menu = ckas_pkg::MENU_DATE;
			end else if (menu == ckas_pkg::MENU_DATE) begin
				menu = ckas_pkg::MENU_ALARM;
			end else begin
				menu = ckas_pkg::MENU_RUN;
			end
		end

		// Set key walks the fields inside each group.
		menu_inc = menu + 4'd1;
		if (set_edge) begin
			case (menu_inc)
				ckas_pkg::MENU_HOUR_WRAP:  menu = ckas_pkg::MENU_HOUR;
				ckas_pkg::MENU_DATE_WRAP:  menu = ckas_pkg::MENU_DAY;
				ckas_pkg::MENU_ALARM_WRAP: menu = ckas_pkg::MENU_ALARM_ON;
				default:                   menu = menu_inc;
			endcase
		end
		nxt.menu = menu;

		edit_menu = (menu inside {ckas_pkg::MENU_HOUR, ckas_pkg::MENU_MINUTE,
			ckas_pkg::MENU_DAY, ckas_pkg::MENU_MONTH, ckas_pkg::MENU_YEAR,
			ckas_pkg::MENU_ALARM_ON, ckas_pkg::MENU_ALARM_HOUR,
			ckas_pkg::MENU_ALARM_MIN});
		if (edit_menu) begin
			up_edge       = cur.up_prev & ~item.up_key;
			down_edge     = cur.down_prev & ~item.down_key;
			nxt.up_prev   = item.up_key;
			nxt.down_prev = item.down_key;
		end

		case (menu)
			ckas_pkg::MENU_HOUR: begin
				nxt.hour  = 5'(ckas_pkg::adjust({2'b0, cur.hour}, up_edge, down_edge,
					ckas_pkg::LIM_HOUR, 7'd0));
				nxt.dirty = 1'b1;
			end
			ckas_pkg::MENU_MINUTE: begin
				nxt.minute = 6'(ckas_pkg::adjust({1'b0, cur.minute}, up_edge,
					down_edge, ckas_pkg::LIM_MINUTE, 7'd0));
				nxt.dirty  = 1'b1;
			end
			ckas_pkg::MENU_DAY: begin
				nxt.day   = 5'(ckas_pkg::adjust({2'b0, cur.day}, up_edge, down_edge,
					ckas_pkg::LIM_DAY, 7'd1));
				nxt.dirty = 1'b1;
			end
			ckas_pkg::MENU_MONTH: begin
				nxt.month = 4'(ckas_pkg::adjust({3'b0, cur.month}, up_edge, down_edge,
					ckas_pkg::LIM_MONTH, 7'd1));
				nxt.dirty = 1'b1;
			end
			ckas_pkg::MENU_YEAR: begin
				nxt.year  = ckas_pkg::adjust(cur.year, up_edge, down_edge,
					ckas_pkg::LIM_YEAR, 7'd0);
				nxt.dirty = 1'b1;
			end
			ckas_pkg::MENU_ALARM_ON: begin
				// Up toggles and arms along with it; down only toggles.
				if (up_edge) begin
					nxt.alarm_on    = ~cur.alarm_on;
					nxt.alarm_armed = ~cur.alarm_on;
				end
				if (down_edge) begin
					nxt.alarm_on = nxt.alarm_on ^ 1'b1;
				end
				nxt.dirty = 1'b1;
			end
			ckas_pkg::MENU_ALARM_HOUR: begin
				nxt.alarm_hour = 5'(ckas_pkg::adjust({2'b0, cur.alarm_hour}, up_edge,
					down_edge, ckas_pkg::LIM_HOUR, 7'd0));
			end
			ckas_pkg::MENU_ALARM_MIN: begin
				nxt.alarm_minute = 6'(ckas_pkg::adjust({1'b0, cur.alarm_minute},
					up_edge, down_edge, ckas_pkg::LIM_MINUTE, 7'd0));
			end
			default: begin
			end
		endcase

		// In run mode: flush edits once, else track the chip.
		if (menu == ckas_pkg::MENU_RUN) begin
			if (nxt.dirty) begin
				wb        = 1'b1;
				nxt.dirty = 1'b0;
			end else begin
				nxt.second = item.rtc_second;
				nxt.minute = item.rtc_minute;
				nxt.hour   = item.rtc_hour;
				nxt.day    = item.rtc_day;
				nxt.month  = item.rtc_month;
				nxt.year   = item.rtc_year;
			end
		end

		chime    = (nxt.minute == 6'd0) && (nxt.second <= ckas_pkg::CHIME_SECS);
		min_plus = {1'b0, nxt.minute} + 7'd1;

		if (nxt.alarm_on) begin
			if (nxt.alarm_armed && (nxt.alarm_minute == nxt.minute) &&
					(nxt.alarm_hour == nxt.hour)) begin
				ring = 1'b1;
				if (mode_edge) begin
					nxt.alarm_armed = 1'b0;
				end
			end else if ({1'b0, nxt.alarm_minute} == min_plus) begin
				nxt.alarm_armed = 1'b1;
			end
		end

		res.menu_mode        = nxt.menu;
		res.shown_hour       = nxt.hour;
		res.shown_minute     = nxt.minute;
		res.shown_second     = nxt.second;
		res.shown_day        = nxt.day;
		res.shown_month      = nxt.month;
		res.shown_year       = nxt.year;
		res.alarm_hour_out   = nxt.alarm_hour;
		res.alarm_minute_out = nxt.alarm_minute;
		res.alarm_enabled    = nxt.alarm_on;
		res.write_back       = wb;
		res.beep             = chime | ring;
	end

endmodule

`default_nettype wire

### hdl/clock_key_setting_and_alarm_core.sv
// Top level of the clock key setting and alarm core: input register, state
// registers and result register around ckas_step. Depends on ckas_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   s_axis_tdata[39:0]: keys, chip time
// m_axis    out        m_axis_tvalid/m_axis_tready   m_axis_tdata[55:0]: menu, time, alarm
//
// One poll request is taken per clock cycle while the result register drains or
// is empty. A request is held in the input register; ckas_step then updates
// the state registers and loads the result register in the same edge.
// arst_n clears the state to run menu, keys released, all fields zero.
// A stalled result holds in the result register; the input register keeps
// accepting as long as the result register drains or is empty.

module clock_key_setting_and_alarm_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// mode_key, set_key, up_key, down_key, rtc_second, rtc_minute, rtc_hour,
	// rtc_day, rtc_month, rtc_year, 3 zero bits
	input  wire  [ckas_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// menu_mode, shown_hour, shown_minute, shown_second, shown_day, shown_month,
	// shown_year, alarm_hour_out, alarm_minute_out, alarm_enabled, write_back,
	// beep, 5 zero bits
	output logic [ckas_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

	ckas_pkg::in_item_t  in_item;
	ckas_pkg::in_item_t  item_s1;
	logic                valid_s1;
	ckas_pkg::state_t    state_q;
	ckas_pkg::state_t    state_nxt;
	ckas_pkg::out_item_t res;
	logic                advance;

	// Unpack the request, first field at bit 0.
	assign in_item.mode_key   = s_axis_tdata[0];
	assign in_item.set_key    = s_axis_tdata[1];
	assign in_item.up_key     = s_axis_tdata[2];
	assign in_item.down_key   = s_axis_tdata[3];
	assign in_item.rtc_second = s_axis_tdata[9:4];
	assign in_item.rtc_minute = s_axis_tdata[15:10];
	assign in_item.rtc_hour   = s_axis_tdata[20:16];
	assign in_item.rtc_day    = s_axis_tdata[25:21];
	assign in_item.rtc_month  = s_axis_tdata[29:26];
	assign in_item.rtc_year   = s_axis_tdata[36:30];

	// Move the held request on when the result register is free or drains now.
	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= in_item;
		end
	end

	ckas_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res)
	);

	// Commit the state only when the request actually moves to the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ckas_pkg::STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (advance) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	// Pack the result, first field at bit 0, pad with zeros.
	always_ff @(posedge clk) begin
		if (advance) begin
			m_axis_tdata <= {5'b0, res.beep, res.write_back, res.alarm_enabled,
				res.alarm_minute_out, res.alarm_hour_out, res.shown_year,
				res.shown_month, res.shown_day, res.shown_second, res.shown_minute,
				res.shown_hour, res.menu_mode};
		end
	end

endmodule

`default_nettype wire
